### src/accumulator_core_execute_assert.svh
// ----------------------------------------------------------------------------
// Accumulator core assertion macros
// Shared property macros for the accumulator core checks.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CORE_EXECUTE_ASSERT_SVH
`define ACCUMULATOR_CORE_EXECUTE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ACE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/ace_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator core package
// Opcodes, status codes, controller states and the control structs.
// ----------------------------------------------------------------------------
package ace_pkg;

  localparam int unsigned MEMORY_WORDS = 256;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PC_W = 9;
  localparam int unsigned START_W = 8;

  localparam logic [7:0] OP_ADD   = 8'd1;
  localparam logic [7:0] OP_SUB   = 8'd2;
  localparam logic [7:0] OP_LOAD  = 8'd3;
  localparam logic [7:0] OP_STORE = 8'd4;
  localparam logic [7:0] OP_MUL   = 8'd5;
  localparam logic [7:0] OP_DIV   = 8'd6;
  localparam logic [7:0] OP_AND   = 8'd7;
  localparam logic [7:0] OP_OR    = 8'd8;
  localparam logic [7:0] OP_JMP   = 8'd9;
  localparam logic [7:0] OP_JZ    = 8'd10;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_DIV_ZERO  = 3'd1;
  localparam logic [2:0] STAT_BAD_JUMP  = 3'd2;
  localparam logic [2:0] STAT_BAD_OP    = 3'd3;
  localparam logic [2:0] STAT_BAD_STORE = 3'd4;
  localparam logic [2:0] STAT_IGNORED   = 3'd5;

  localparam logic       CFG_REGION_START = 1'b0;
  localparam logic       CFG_REGION_END   = 1'b1;

  localparam logic [PC_W-1:0] PC_STEP        = 9'd2;
  localparam logic [PC_W-1:0] REGION_END_RST = 9'd19;
  localparam logic [WORD_W-1:0] MEM_LIMIT    = WORD_W'(MEMORY_WORDS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage

### src/ace_div.sv
// ----------------------------------------------------------------------------
// Accumulator core divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ace_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = 32'd0;
      quo_nxt  = dividend[31] ? (~dividend + 32'd1) : dividend;
      dvs_nxt  = divisor[31] ? (~divisor + 32'd1) : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 32'd1) : quo_r;

endmodule

### src/ace_datapath.sv
// ----------------------------------------------------------------------------
// Accumulator core datapath
// Architectural state, instruction execution and the result registers.
// ----------------------------------------------------------------------------
module ace_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ace_pkg::ctrl_cmd_t  cmd,
  output ace_pkg::dp_status_t sts,
  input  logic [7:0]          in_opcode,
  input  logic [31:0]         in_operand_word,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_wdata,
  output logic [8:0]          out_next_pc,
  output logic [31:0]         out_acc_value,
  output logic                out_store_valid,
  output logic [7:0]          out_store_address,
  output logic [31:0]         out_store_data,
  output logic [2:0]          out_status,
  output logic                out_halted
);

  logic [7:0]  op_r;
  logic [31:0] arg_r;
  logic [31:0] acc_r, acc_nxt;
  logic [8:0]  pc_r, pc_nxt;
  logic        zero_r, zero_nxt;
  logic        halt_r, halt_nxt;
  logic [7:0]  rs_r;
  logic [8:0]  re_r;

  logic [8:0]  opc_r;
  logic [31:0] oacc_r;
  logic        ostv_r, stv_nxt;
  logic [7:0]  osta_r, sta_nxt;
  logic [31:0] ostd_r, std_nxt;
  logic [2:0]  ostat_r, stat_nxt;

  logic [31:0] mul_lo;
  logic [31:0] div_q;
  logic        div_done;
  logic        need_div;
  logic        jump_ok;
  logic        pc_ok;
  logic        jumped;
  logic [8:0]  pc_inc;

  ace_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .divisor  (in_operand_word),
    .done     (div_done),
    .quotient (div_q)
  );

  assign need_div = !halt_r && (in_opcode == ace_pkg::OP_DIV) &&
                    (in_operand_word != 32'd0);
  assign sts      = '{need_div: need_div, div_done: div_done};

  assign mul_lo  = acc_r * arg_r;
  assign pc_inc  = pc_r + ace_pkg::PC_STEP;
  assign jump_ok = !arg_r[31] && (arg_r >= {24'd0, rs_r}) && (arg_r < {23'd0, re_r});

  always_comb begin
    acc_nxt  = acc_r;
    stv_nxt  = 1'b0;
    sta_nxt  = 8'd0;
    std_nxt  = 32'd0;
    stat_nxt = ace_pkg::STAT_OK;
    jumped   = 1'b0;
    case (op_r)
      ace_pkg::OP_ADD:  acc_nxt = acc_r + arg_r;
      ace_pkg::OP_SUB:  acc_nxt = acc_r - arg_r;
      ace_pkg::OP_LOAD: acc_nxt = arg_r;
      ace_pkg::OP_MUL:  acc_nxt = mul_lo;
      ace_pkg::OP_AND:  acc_nxt = acc_r & arg_r;
      ace_pkg::OP_OR:   acc_nxt = acc_r | arg_r;
      ace_pkg::OP_DIV: begin
        if (arg_r == 32'd0) begin
          stat_nxt = ace_pkg::STAT_DIV_ZERO;
        end else begin
          acc_nxt = div_q;
        end
      end
      ace_pkg::OP_STORE: begin
        if (!arg_r[31] && (arg_r < ace_pkg::MEM_LIMIT)) begin
          stv_nxt = 1'b1;
          sta_nxt = arg_r[7:0];
          std_nxt = acc_r;
        end else begin
          stat_nxt = ace_pkg::STAT_BAD_STORE;
        end
      end
      ace_pkg::OP_JMP, ace_pkg::OP_JZ: begin
        if ((op_r == ace_pkg::OP_JMP) || zero_r) begin
          if (jump_ok) begin
            jumped = 1'b1;
          end else begin
            stat_nxt = ace_pkg::STAT_BAD_JUMP;
          end
        end
      end
      default: stat_nxt = ace_pkg::STAT_BAD_OP;
    endcase
    pc_nxt   = jumped ? arg_r[8:0] : pc_inc;
    zero_nxt = (acc_nxt == 32'd0);
    pc_ok    = (pc_nxt >= {1'b0, rs_r}) && (pc_nxt < re_r);
    halt_nxt = (stat_nxt != ace_pkg::STAT_OK) || !pc_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 32'd0;
      pc_r   <= 9'd0;
      zero_r <= 1'b0;
      halt_r <= 1'b0;
      rs_r   <= 8'd0;
      re_r   <= ace_pkg::REGION_END_RST;
    end else begin
      if (cmd.commit && !halt_r) begin
        acc_r  <= acc_nxt;
        pc_r   <= pc_nxt;
        zero_r <= zero_nxt;
        halt_r <= halt_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          ace_pkg::CFG_REGION_START: begin
            rs_r <= cfg_wdata[7:0];
            pc_r <= {1'b0, cfg_wdata[7:0]};
          end
          ace_pkg::CFG_REGION_END: re_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      arg_r <= in_operand_word;
    end
    if (cmd.commit) begin
      if (halt_r) begin
        opc_r   <= pc_r;
        oacc_r  <= acc_r;
        ostv_r  <= 1'b0;
        osta_r  <= 8'd0;
        ostd_r  <= 32'd0;
        ostat_r <= ace_pkg::STAT_IGNORED;
      end else begin
        opc_r   <= pc_nxt;
        oacc_r  <= acc_nxt;
        ostv_r  <= stv_nxt;
        osta_r  <= sta_nxt;
        ostd_r  <= std_nxt;
        ostat_r <= stat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_halted <= 1'b0;
    end else if (cmd.commit) begin
      out_halted <= halt_r || halt_nxt;
    end
  end

  assign out_next_pc       = opc_r;
  assign out_acc_value     = oacc_r;
  assign out_store_valid   = ostv_r;
  assign out_store_address = osta_r;
  assign out_store_data    = ostd_r;
  assign out_status        = ostat_r;

endmodule

### src/ace_ctrl.sv
// ----------------------------------------------------------------------------
// Accumulator core controller
// Sequences accept, divide and commit, and owns both handshakes.
// ----------------------------------------------------------------------------
module ace_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ace_pkg::dp_status_t sts,
  output ace_pkg::ctrl_cmd_t  cmd
);

  ace_pkg::state_t state_r, state_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            slot_free;

  assign slot_free = !ovalid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ace_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_div ? ace_pkg::ST_DIV : ace_pkg::ST_EXEC;
        end
      end
      ace_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ace_pkg::ST_EXEC;
        end
      end
      ace_pkg::ST_EXEC: begin
        if (slot_free) begin
          state_nxt = ace_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ace_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ace_pkg::ST_IDLE);
    cmd.load      = in_ready && in_valid;
    cmd.div_start = in_ready && in_valid && sts.need_div;
    cmd.commit    = (state_r == ace_pkg::ST_EXEC) && slot_free;
    if (cmd.commit) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ace_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

endmodule

### src/accumulator_core_execute.sv
// ----------------------------------------------------------------------------
// Accumulator core execute stage
// Executes one accumulator instruction per item and reports one result.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    opcode, operand word
//   out      output     out_valid/out_ready  pc, acc, store request, status
//   cfg      input      cfg_we               region start, region end
//
// An item passes through accept and commit; a divide by a nonzero operand
// also waits between them for the one-bit-per-cycle divider.
// One item is in work at a time.
// A new item is taken while the previous result waits in the output register.
// A stalled output holds the item in the commit state until the slot frees.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "accumulator_core_execute_assert.svh"

module accumulator_core_execute (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_opcode,
  input  logic signed [31:0] in_operand_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         out_next_pc,
  output logic signed [31:0] out_acc_value,
  output logic               out_store_valid,
  output logic [7:0]         out_store_address,
  output logic signed [31:0] out_store_data,
  output logic [2:0]         out_status,
  output logic               out_halted,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_wdata
);

  ace_pkg::ctrl_cmd_t  cmd;
  ace_pkg::dp_status_t sts;

  ace_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ace_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_operand_word   (in_operand_word),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_next_pc       (out_next_pc),
    .out_acc_value     (out_acc_value),
    .out_store_valid   (out_store_valid),
    .out_store_address (out_store_address),
    .out_store_data    (out_store_data),
    .out_status        (out_status),
    .out_halted        (out_halted)
  );

  `ACE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `ACE_ASSERT_IMPL(a_error_halts, clk, rst_n, out_valid && (out_status != ace_pkg::STAT_OK), out_halted)
  `ACE_ASSERT_IMPL(a_store_ok, clk, rst_n, out_valid && out_store_valid, out_status == ace_pkg::STAT_OK)
  `ACE_ASSERT_IMPL(a_commit_has_slot, clk, rst_n, cmd.commit && out_valid, out_ready)

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Accumulator core execute testbench
// Instruction items go in over a valid/ready channel. A behavioral model of
// the core inside the bench predicts each result, and every result that comes
// out is checked against it field by field. Programs are built to keep the PC
// inside the region so that the core keeps running through several region
// settings. Each run ends with one halting case chosen at random, followed by
// items that must be ignored.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ace_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES = 60;
  localparam int HOLD_AFTER = 150;

  typedef struct packed {
    logic [WORD_W-1:0]  acc;
    logic [PC_W-1:0]    pc;
    logic               zero;
    logic               err;
    logic               halt;
    logic [START_W-1:0] rstart;
    logic [PC_W-1:0]    rend;
  } core_t;

  typedef struct packed {
    logic [7:0]        opcode;
    logic [WORD_W-1:0] operand;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic [WORD_W-1:0] acc;
    logic              st_valid;
    logic [7:0]        st_addr;
    logic [WORD_W-1:0] st_data;
    logic [2:0]        status;
    logic              halted;
  } retire_t;

  typedef struct packed {
    core_t   core;
    retire_t ret;
  } step_t;

  typedef enum {
    END_DIV_ZERO,
    END_BAD_JUMP,
    END_BAD_OP,
    END_BAD_STORE,
    END_LEAVE_REGION,
    END_CLOSED_REGION
  } halt_cause_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_opcode = '0;
  logic signed [31:0] in_operand_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [8:0]         out_next_pc;
  logic signed [31:0] out_acc_value;
  logic               out_store_valid;
  logic [7:0]         out_store_address;
  logic signed [31:0] out_store_data;
  logic [2:0]         out_status;
  logic               out_halted;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_REGION_START;
  logic [8:0]         cfg_wdata = '0;

  instr_t      pending_instrs[$];
  retire_t     expected_retires[$];
  core_t       core_model;
  core_t       plan_core;
  instr_t      took;
  instr_t      next_instr;
  step_t       stepped;
  retire_t     want;
  halt_cause_t halt_cause;
  logic        in_took = 1'b0;
  logic        quiet = 1'b0;
  logic        hold_done = 1'b0;
  int          cycle_count = 0;
  int          items_queued = 0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          stores_seen = 0;
  int          ignored_seen = 0;
  int          failures = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;

  wire no_idle = quiet || (cycle_count[7:6] == 2'b11);

  accumulator_core_execute u_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic core_t reset_core();
    core_t s;
    s = '0;
    s.rend = REGION_END_RST;
    return s;
  endfunction

  function automatic logic in_region(core_t s, logic [WORD_W-1:0] addr);
    longint a;
    a = longint'($signed(addr));
    return a >= longint'(s.rstart) && a < longint'(s.rend);
  endfunction

  function automatic core_t region_write(core_t s, logic idx, logic [8:0] val);
    core_t r;
    r = s;
    if (idx == CFG_REGION_START) begin
      r.rstart = val[START_W-1:0];
      r.pc = {1'b0, val[START_W-1:0]};
    end else begin
      r.rend = val;
    end
    return r;
  endfunction

  function automatic step_t execute_instr(core_t s, instr_t i);
    step_t      r;
    longint     q;
    longint     sarg;
    logic       jumped;
    logic [2:0] st;
    r.core = s;
    r.ret = '0;
    jumped = 1'b0;
    st = STAT_OK;
    sarg = longint'($signed(i.operand));
    if (s.halt) begin
      r.ret.next_pc = s.pc;
      r.ret.acc = s.acc;
      r.ret.status = STAT_IGNORED;
      r.ret.halted = 1'b1;
      return r;
    end
    case (i.opcode)
      OP_ADD:  r.core.acc = s.acc + i.operand;
      OP_SUB:  r.core.acc = s.acc - i.operand;
      OP_LOAD: r.core.acc = i.operand;
      OP_MUL:  r.core.acc = s.acc * i.operand;
      OP_DIV: begin
        if (i.operand == '0) begin
          st = STAT_DIV_ZERO;
        end else begin
          q = longint'($signed(s.acc)) / sarg;
          r.core.acc = q[31:0];
        end
      end
      OP_AND:  r.core.acc = s.acc & i.operand;
      OP_OR:   r.core.acc = s.acc | i.operand;
      OP_STORE: begin
        if (sarg >= 0 && sarg < longint'(MEMORY_WORDS)) begin
          r.ret.st_valid = 1'b1;
          r.ret.st_addr = i.operand[7:0];
          r.ret.st_data = s.acc;
        end else begin
          st = STAT_BAD_STORE;
        end
      end
      OP_JMP, OP_JZ: begin
        if (i.opcode == OP_JMP || s.zero) begin
          if (in_region(s, i.operand)) jumped = 1'b1;
          else st = STAT_BAD_JUMP;
        end
      end
      default: st = STAT_BAD_OP;
    endcase
    r.core.pc = jumped ? i.operand[PC_W-1:0] : s.pc + PC_STEP;
    r.core.zero = (r.core.acc == '0);
    if (st != STAT_OK) begin
      r.core.err = 1'b1;
      r.core.halt = 1'b1;
    end else if (!in_region(r.core, WORD_W'(r.core.pc))) begin
      r.core.halt = 1'b1;
    end
    r.ret.next_pc = r.core.pc;
    r.ret.acc = r.core.acc;
    r.ret.status = st;
    r.ret.halted = r.core.halt;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(1, 15));
      5: return -32'($urandom_range(1, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] region_target(core_t s);
    return 32'($urandom_range(s.rend - 1, s.rstart));
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Draws a legal instruction; anything that would halt the core becomes a
  // jump back into the region.
  function automatic instr_t pick_program_item(core_t s);
    instr_t     c;
    step_t      trial;
    logic [7:0] ops [10];
    ops = '{OP_ADD, OP_SUB, OP_LOAD, OP_STORE, OP_MUL,
            OP_DIV, OP_AND, OP_OR, OP_JMP, OP_JZ};
    c.opcode = ops[$urandom_range(0, 9)];
    c.operand = rand_word();
    case (c.opcode)
      OP_SUB: if ($urandom_range(0, 3) == 0) c.operand = s.acc;
      OP_DIV: if (c.operand == '0) c.operand = 32'($urandom_range(1, 9));
      OP_STORE: begin
        if ($urandom_range(0, 3) == 0) c.operand = MEMORY_WORDS - 1;
        else c.operand = 32'($urandom_range(0, MEMORY_WORDS - 1));
      end
      OP_JMP: c.operand = region_target(s);
      OP_JZ: if (s.zero) c.operand = region_target(s);
      default: ;
    endcase
    trial = execute_instr(s, c);
    if (trial.core.halt) begin
      c.opcode = OP_JMP;
      c.operand = region_target(s);
    end
    return c;
  endfunction

  task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      failures++;
    end
  endtask

  task automatic queue_item(logic [7:0] op, logic [WORD_W-1:0] arg);
    instr_t it;
    step_t  st;
    it.opcode = op;
    it.operand = arg;
    pending_instrs.push_back(it);
    st = execute_instr(plan_core, it);
    plan_core = st.core;
    items_queued++;
  endtask

  task automatic write_region(logic idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    plan_core = region_write(plan_core, idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || expected_retires.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [8:0] end_addr, logic [7:0] start_addr, int count);
    instr_t pick;
    write_region(CFG_REGION_END, end_addr);
    write_region(CFG_REGION_START, {1'b0, start_addr});
    @(posedge clk);
    repeat (count) begin
      pick = pick_program_item(plan_core);
      queue_item(pick.opcode, pick.operand);
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("** accumulator_core_execute: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_instrs.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        send_gap = no_idle ? 0 : draw_gap();
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else begin
          next_instr = pending_instrs.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_instr.opcode;
          in_operand_word <= next_instr.operand;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      recv_gap = no_idle ? 0 : draw_gap();
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      core_model = reset_core();
    end else begin
      in_took <= in_valid && in_ready;
      if (cfg_we) core_model = region_write(core_model, cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        took.opcode = in_opcode;
        took.operand = in_operand_word;
        stepped = execute_instr(core_model, took);
        core_model = stepped.core;
        expected_retires.push_back(stepped.ret);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_retires.size() == 0) begin
          $error("result with no item pending: pc %0h status %0d", out_next_pc, out_status);
          failures++;
        end else begin
          want = expected_retires.pop_front();
          compare_field("next_pc", 32'(want.next_pc), 32'(out_next_pc));
          compare_field("acc_value", want.acc, out_acc_value);
          compare_field("store_valid", 32'(want.st_valid), 32'(out_store_valid));
          compare_field("store_address", 32'(want.st_addr), 32'(out_store_address));
          compare_field("store_data", want.st_data, out_store_data);
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("halted", 32'(want.halted), 32'(out_halted));
          if (out_store_valid) stores_seen++;
          if (out_status == STAT_IGNORED) ignored_seen++;
        end
      end
    end
  end

  initial begin
    logic [7:0]        lo;
    logic [8:0]        hi;
    logic [7:0]        bad_op;
    logic [WORD_W-1:0] target;
    plan_core = reset_core();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The zero flag starts clear, so the first JZ falls through.
    queue_item(OP_JZ, 32'd5);
    queue_item(OP_LOAD, 32'h7fff_ffff);
    queue_item(OP_ADD, 32'd1);
    queue_item(OP_SUB, 32'd1);
    queue_item(OP_MUL, 32'h7fff_ffff);
    queue_item(OP_LOAD, 32'h8000_0000);
    queue_item(OP_DIV, 32'hffff_ffff);
    queue_item(OP_DIV, 32'd7);
    queue_item(OP_JMP, 32'd0);
    queue_item(OP_STORE, 32'd0);
    queue_item(OP_STORE, 32'd255);
    queue_item(OP_AND, 32'd0);
    queue_item(OP_JZ, 32'd18);
    queue_item(OP_JMP, 32'd0);
    queue_item(OP_OR, 32'hffff_ffff);
    queue_item(OP_MUL, 32'hffff_ffff);
    queue_item(OP_JZ, 32'h8000_0000);
    queue_item(OP_LOAD, -32'd7);
    queue_item(OP_DIV, 32'd2);
    queue_item(OP_SUB, -32'd3);
    queue_item(OP_JZ, 32'd0);
    wait_idle();

    run_phase(9'd256, 8'd0, 340);
    run_phase(9'd256, 8'd255, 40);
    run_phase(9'd1, 8'd0, 40);
    lo = 8'($urandom_range(0, 200));
    hi = 9'(lo + $urandom_range(1, 56));
    run_phase(hi, lo, 200);
    run_phase(REGION_END_RST, 8'd0, 150);

    quiet = 1'b1;
    lo = 8'($urandom_range(0, 250));
    hi = 9'($urandom_range(lo + 1, 256));
    run_phase(hi, lo, 120);

    halt_cause = halt_cause_t'($urandom_range(0, 5));
    @(posedge clk);
    case (halt_cause)
      END_DIV_ZERO: queue_item(OP_DIV, '0);
      END_BAD_JUMP: begin
        case ($urandom_range(0, 2))
          0: target = 32'(plan_core.rend);
          1: target = 32'(plan_core.rstart) - 32'd1;
          default: target = $urandom | 32'h8000_0000;
        endcase
        queue_item(plan_core.zero ? OP_JZ : OP_JMP, target);
      end
      END_BAD_OP: begin
        do bad_op = 8'($urandom_range(0, 255));
        while (bad_op >= OP_ADD && bad_op <= OP_JZ);
        queue_item(bad_op, $urandom);
      end
      END_BAD_STORE: begin
        case ($urandom_range(0, 2))
          0: target = 32'hffff_ffff;
          1: target = 32'(MEMORY_WORDS);
          default: target = 32'h8000_0000;
        endcase
        queue_item(OP_STORE, target);
      end
      END_LEAVE_REGION: begin
        queue_item(OP_JMP, 32'(plan_core.rend) - 32'd1);
        queue_item(OP_LOAD, rand_word());
      end
      default: begin
        wait_idle();
        write_region(CFG_REGION_END, 9'd0);
        @(posedge clk);
        queue_item(OP_ADD, rand_word());
      end
    endcase
    wait_idle();

    // Region writes move the PC but must not bring the core out of its halt.
    write_region(CFG_REGION_END, 9'd0);
    write_region(CFG_REGION_START, {1'b0, 8'($urandom_range(0, 255))});
    @(posedge clk);
    repeat (25) queue_item(8'($urandom_range(0, 255)), $urandom);
    wait_idle();
    repeat (30) @(negedge clk);

    if (expected_retires.size() != 0) begin
      $error("%0d expected results never arrived", expected_retires.size());
    end
    $display("Ran %0d items to %0d results in %0d cycles: %0d stores, %0d ignored while halted.",
             items_taken, results_seen, cycle_count, stores_seen, ignored_seen);
    $display("Regions from one word to all of memory were used; the core halted by %s.",
             halt_cause.name());
    if (failures == 0 && expected_retires.size() == 0)
      $display("** accumulator_core_execute: PASSED **");
    else
      $display("** accumulator_core_execute: FAILED **");
    $finish;
  end

endmodule
